// File: hdl/qmr_pkg.sv
package qmr_pkg;

  localparam int QW        = 16;
  localparam int BW        = QW + 1;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = QW + BW;
  localparam int ACC_W     = PROD_W + 2;

  localparam logic [1:0] FUNC_MUL  = 2'd0;
  localparam logic [1:0] FUNC_CONJ = 2'd1;
  localparam logic [1:0] FUNC_ROT  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [BW-1:0] w;
    logic signed [BW-1:0] x;
    logic signed [BW-1:0] y;
    logic signed [BW-1:0] z;
  } quatb_t;

  // Sideband that rides along with an item through a product unit.
  typedef struct packed {
    logic [1:0] func;
    quat_t      q;
    quat_t      t;
    logic       sat;
  } side_t;

  function automatic logic over16(input logic signed [ACC_W-1:0] v);
    return (v > ACC_W'(Q_MAX)) || (v < ACC_W'(Q_MIN));
  endfunction

  function automatic logic signed [QW-1:0] clamp16(input logic signed [ACC_W-1:0] v);
    logic signed [QW-1:0] r;
    if (v > ACC_W'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < ACC_W'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/qmr_if.sv
interface qmr_cmd_if import qmr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [QW-1:0] q_w;
  logic signed [QW-1:0] q_x;
  logic signed [QW-1:0] q_y;
  logic signed [QW-1:0] q_z;
  logic signed [QW-1:0] p_w;
  logic signed [QW-1:0] p_x;
  logic signed [QW-1:0] p_y;
  logic signed [QW-1:0] p_z;

  modport source (output valid, func, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z,
                  input ready);
  modport sink (input valid, func, q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z,
                output ready);
endinterface

interface qmr_res_if import qmr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] r_w;
  logic signed [QW-1:0] r_x;
  logic signed [QW-1:0] r_y;
  logic signed [QW-1:0] r_z;
  logic                 saturated;

  modport source (output valid, r_w, r_x, r_y, r_z, saturated, input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, saturated, output ready);
endinterface

// File: hdl/qmr_hamilton.sv
module qmr_hamilton import qmr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  quat_t  a,
  input  quatb_t b,
  input  side_t  side_in,
  output logic   out_valid,
  input  logic   out_ready,
  output quat_t  res,
  output logic   res_sat,
  output side_t  side_out
);

  logic signed [QW-1:0]     ac [4];
  logic signed [BW-1:0]     bc [4];
  logic signed [PROD_W-1:0] prod [4][4];
  logic signed [ACC_W-1:0]  pe [4][4];
  logic signed [ACC_W-1:0]  sum_next [4];
  logic signed [ACC_W-1:0]  sum [4];
  logic signed [ACC_W-1:0]  rnd [4];
  logic                     v1, v2, v3;
  logic                     rdy1, rdy2, rdy3;
  side_t                    side1, side2, side3;
  quat_t                    res_next;
  logic                     sat_next;
  quat_t                    res_q;
  logic                     sat_q;

  assign ac = '{a.w, a.x, a.y, a.z};
  assign bc = '{b.w, b.x, b.y, b.z};

  // A stage advances when it is empty or the next one moves.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: sixteen partial products.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= ac[i] * bc[j];
        end
      end
      side1 <= side_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = ACC_W'(prod[i][j]);
      end
    end
    sum_next[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
    sum_next[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
    sum_next[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
    sum_next[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
  end

  // Stage 2: Hamilton sums at full width.
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sum   <= sum_next;
      side2 <= side1;
    end
  end

  // Round half up, then clamp.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rnd[k] = (sum[k] + RND_HALF) >>> FRAC_BITS;
    end
    res_next.w = clamp16(rnd[0]);
    res_next.x = clamp16(rnd[1]);
    res_next.y = clamp16(rnd[2]);
    res_next.z = clamp16(rnd[3]);
    sat_next   = side2.sat || over16(rnd[0]) || over16(rnd[1]) ||
                 over16(rnd[2]) || over16(rnd[3]);
  end

  // Stage 3: rounded result.
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      res_q <= res_next;
      sat_q <= sat_next;
      side3 <= side2;
    end
  end

  assign out_valid = v3;
  assign res       = res_q;
  assign res_sat   = sat_q;
  assign side_out  = side3;

endmodule

// File: hdl/quaternion_multiply_rotate.sv
// Quaternion unit: Hamilton product, conjugate and rotation in signed Q2.14.
// An item passes two three-stage product units and one output register.
// Throughput: one item per cycle while the output is not stalled; a stalled
// output holds an item in place once every stage ahead of it is full.
// Reset (rst, synchronous): clears the valid bits; data registers keep junk.
module quaternion_multiply_rotate import qmr_pkg::*; (
  input logic       clk,
  input logic       rst,
  qmr_cmd_if.sink   cmd,
  qmr_res_if.source res
);

  // Stages an item passes: three per product unit plus the output register.
  localparam int DEPTH = 7;
  localparam int CNT_W = $clog2(DEPTH + 1);

  side_t  side_in;
  quatb_t p_ext;
  logic   u1_valid, u1_ready;
  quat_t  u1_res;
  logic   u1_sat;
  side_t  u1_side;
  side_t  side_mid;
  quatb_t q_conj;
  logic   u2_valid, u2_ready;
  quat_t  u2_res;
  logic   u2_sat;
  side_t  u2_side;
  quat_t  r_next;
  logic   sat_next;
  logic   ovalid;
  logic   ordy;
  quat_t  r_out;
  logic   sat_out;
  logic [1:0] func_out;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Carry the operation code and q alongside the first product.
  always_comb begin
    side_in.func = cmd.func;
    side_in.q.w  = cmd.q_w;
    side_in.q.x  = cmd.q_x;
    side_in.q.y  = cmd.q_y;
    side_in.q.z  = cmd.q_z;
    side_in.t    = '0;
    side_in.sat  = 1'b0;
    p_ext.w      = BW'(cmd.p_w);
    p_ext.x      = BW'(cmd.p_x);
    p_ext.y      = BW'(cmd.p_y);
    p_ext.z      = BW'(cmd.p_z);
  end

  // First product t = q*p, rounded and clamped.
  qmr_hamilton u_prod1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (u1_ready),
    .a         (side_in.q),
    .b         (p_ext),
    .side_in   (side_in),
    .out_valid (u1_valid),
    .out_ready (u2_ready),
    .res       (u1_res),
    .res_sat   (u1_sat),
    .side_out  (u1_side)
  );

  assign cmd.ready = u1_ready;

  // Second operand is conj(q) at 17 bits, so negating the most negative
  // component stays exact.
  always_comb begin
    side_mid     = u1_side;
    side_mid.t   = u1_res;
    side_mid.sat = u1_sat;
    q_conj.w     = BW'(u1_side.q.w);
    q_conj.x     = -BW'(u1_side.q.x);
    q_conj.y     = -BW'(u1_side.q.y);
    q_conj.z     = -BW'(u1_side.q.z);
  end

  // Second product t*conj(q); its flag includes the first product's clamps.
  qmr_hamilton u_prod2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (u1_valid),
    .in_ready  (u2_ready),
    .a         (u1_res),
    .b         (q_conj),
    .side_in   (side_mid),
    .out_valid (u2_valid),
    .out_ready (ordy),
    .res       (u2_res),
    .res_sat   (u2_sat),
    .side_out  (u2_side)
  );

  // Pick the answer by operation code. Conjugate negates q here: only the
  // most negative value clamps.
  always_comb begin
    r_next   = '0;
    sat_next = 1'b0;
    case (u2_side.func)
      FUNC_MUL: begin
        r_next   = u2_side.t;
        sat_next = u2_side.sat;
      end
      FUNC_CONJ: begin
        r_next.w = u2_side.q.w;
        r_next.x = clamp16(-ACC_W'(u2_side.q.x));
        r_next.y = clamp16(-ACC_W'(u2_side.q.y));
        r_next.z = clamp16(-ACC_W'(u2_side.q.z));
        sat_next = (u2_side.q.x == Q_MIN) || (u2_side.q.y == Q_MIN) ||
                   (u2_side.q.z == Q_MIN);
      end
      FUNC_ROT: begin
        r_next   = u2_res;
        sat_next = u2_sat;
      end
      default: begin
        r_next   = '0;
        sat_next = 1'b0;
      end
    endcase
  end

  // Output register: take a new item whenever the slot is free or drains.
  assign ordy = !ovalid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (ordy) begin
      ovalid <= u2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ordy && u2_valid) begin
      r_out    <= r_next;
      sat_out  <= sat_next;
      func_out <= u2_side.func;
    end
  end

  assign res.valid     = ovalid;
  assign res.r_w       = r_out.w;
  assign res.r_x       = r_out.x;
  assign res.r_y       = r_out.y;
  assign res.r_z       = r_out.z;
  assign res.saturated = sat_out;

  // Items in flight, for the checks below.
  always_comb begin
    cnt_next = cnt;
    if (cmd.valid && cmd.ready) cnt_next = cnt_next + CNT_W'(1);
    if (res.valid && res.ready) cnt_next = cnt_next - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Input backpressure only when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> cnt == CNT_W'(DEPTH))
    else $error("input stalled with a free stage");

  // A result is never offered with nothing in flight.
  a_valid_has_item: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> cnt != '0)
    else $error("result offered with empty pipeline");

  // The unused code yields a zero quaternion and no flag.
  a_unused_code_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && func_out == FUNC_NONE) |->
      (res.r_w == '0 && res.r_x == '0 && res.r_y == '0 && res.r_z == '0 &&
       !res.saturated))
    else $error("unused code gave a nonzero result");

endmodule

// File: test/quaternion_multiply_rotate_test.sv
`timescale 1ns / 100ps

module quaternion_multiply_rotate_test;
  import qmr_pkg::*;

  // Run shape: a directed table first, then random items. The tail of the
  // random part runs with both sides streaming so the pipeline stays full.
  localparam int RAND_N       = 1035;
  localparam int CALM_N       = 120;
  localparam int DIR_N        = 18;
  localparam int DRAIN_CYCLES = 16;

  // Component styles for random quaternions.
  localparam int unsigned STYLE_FULL  = 0;
  localparam int unsigned STYLE_UNIT  = 1;
  localparam int unsigned STYLE_EDGE  = 2;
  localparam int unsigned STYLE_MIXED = 3;

  localparam logic signed [QW-1:0] ONE = 16'sd16384;
  localparam logic signed [QW-1:0] TIE = 16'sd8192;
  localparam quat_t QZERO = '0;
  localparam quat_t QID   = {ONE, 16'sd0, 16'sd0, 16'sd0};
  localparam quat_t QMINS = {4{Q_MIN}};
  localparam quat_t QMAXS = {4{Q_MAX}};

  typedef struct packed {
    quat_t r;
    logic  sat;
  } quat_result_t;

  // One row of the directed table. Where "typed" is set, the expected
  // result is written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]   func;
    quat_t        q;
    quat_t        p;
    logic         typed;
    quat_result_t known;
  } dir_row_t;

  typedef struct {
    longint w;
    longint x;
    longint y;
    longint z;
  } wide_quat_t;

  logic clk = 1'b0;
  logic rst;

  qmr_cmd_if cmd_ch ();
  qmr_res_if res_ch ();

  quat_result_t pending_quats[$];
  int           mismatches = 0;
  bit           calm       = 1'b0;
  int unsigned  gap_pct    = 20;

  dir_row_t dir_rows [DIR_N] = '{
    // Multiply: identity, zero, both extremes, ties in both directions, i*j = k.
    '{FUNC_MUL, QID, QID, 1'b1, '{QID, 1'b0}},
    '{FUNC_MUL, QZERO, {Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 1'b1, '{QZERO, 1'b0}},
    '{FUNC_MUL, QMINS, QMINS, 1'b1, '{{Q_MIN, Q_MAX, Q_MAX, Q_MAX}, 1'b1}},
    '{FUNC_MUL, QMAXS, QMAXS, 1'b0, '0},
    '{FUNC_MUL, QMAXS, QMINS, 1'b0, '0},
    '{FUNC_MUL, {16'sd1, 16'sd0, 16'sd0, 16'sd0}, {TIE, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0}},
    '{FUNC_MUL, {-16'sd1, 16'sd0, 16'sd0, 16'sd0}, {TIE, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
      '{QZERO, 1'b0}},
    '{FUNC_MUL, {16'sd0, ONE, 16'sd0, 16'sd0}, {16'sd0, 16'sd0, ONE, 16'sd0}, 1'b1,
      '{{16'sd0, 16'sd0, 16'sd0, ONE}, 1'b0}},
    // Conjugate: negating the most negative value clamps and flags.
    '{FUNC_CONJ, QMINS, QMAXS, 1'b1, '{{Q_MIN, Q_MAX, Q_MAX, Q_MAX}, 1'b1}},
    '{FUNC_CONJ, QMAXS, QMINS, 1'b1,
      '{{Q_MAX, -16'sd32767, -16'sd32767, -16'sd32767}, 1'b0}},
    '{FUNC_CONJ, {ONE, 16'sd1, -16'sd1, 16'sd0}, QZERO, 1'b1,
      '{{ONE, -16'sd1, 16'sd1, 16'sd0}, 1'b0}},
    // Rotate: identity leaves p alone, then a quarter turn about z; the rest stress the intermediate clamp.
    '{FUNC_ROT, QID, {16'sd0, TIE, -TIE, 16'sd4096}, 1'b1,
      '{{16'sd0, TIE, -TIE, 16'sd4096}, 1'b0}},
    '{FUNC_ROT, {16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, {16'sd0, ONE, 16'sd0, 16'sd0},
      1'b0, '0},
    '{FUNC_ROT, QMINS, QMAXS, 1'b0, '0},
    '{FUNC_ROT, QMAXS, QMINS, 1'b0, '0},
    '{FUNC_ROT, {ONE, -ONE, ONE, -ONE}, {Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 1'b0, '0},
    // Unused code: always a zero quaternion, never flagged.
    '{FUNC_NONE, QMAXS, QMAXS, 1'b1, '{QZERO, 1'b0}},
    '{FUNC_NONE, QMINS, QMINS, 1'b1, '{QZERO, 1'b0}}
  };

  quaternion_multiply_rotate DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: exact sums in 64 bits, one rounding per component of each product.
  // ---------------------------------------------------------------------------

  // Clamp to the Q2.14 range; record any clamp in sat.
  function automatic logic signed [QW-1:0] clip_q(input longint v, inout logic sat);
    if (v > longint'(Q_MAX)) begin
      sat = 1'b1;
      return Q_MAX;
    end
    if (v < longint'(Q_MIN)) begin
      sat = 1'b1;
      return Q_MIN;
    end
    return QW'(v);
  endfunction

  // Round to nearest with ties toward plus infinity: floor(s / 2^14 + 1/2).
  // An arithmetic shift of a signed value is a floor, so no special case.
  function automatic logic signed [QW-1:0] round_fit(input longint s, inout logic sat);
    return clip_q((s + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS, sat);
  endfunction

  function automatic wide_quat_t widen(input quat_t v);
    wide_quat_t r;
    r.w = longint'(v.w);
    r.x = longint'(v.x);
    r.y = longint'(v.y);
    r.z = longint'(v.z);
    return r;
  endfunction

  // Hamilton product with the standard signs.
  function automatic quat_t ham_product(input wide_quat_t a, input wide_quat_t b,
                                        inout logic sat);
    quat_t r;
    r.w = round_fit(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z, sat);
    r.x = round_fit(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y, sat);
    r.y = round_fit(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x, sat);
    r.z = round_fit(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w, sat);
    return r;
  endfunction

  function automatic quat_result_t predict_quat(input logic [1:0] func, input quat_t q,
                                                input quat_t p);
    quat_result_t pred;
    wide_quat_t   qw;
    wide_quat_t   cq;
    quat_t        t;
    logic         sat;
    sat = 1'b0;
    qw  = widen(q);
    case (func)
      FUNC_MUL: pred.r = ham_product(qw, widen(p), sat);
      FUNC_CONJ: begin
        pred.r.w = q.w;
        pred.r.x = clip_q(-qw.x, sat);
        pred.r.y = clip_q(-qw.y, sat);
        pred.r.z = clip_q(-qw.z, sat);
      end
      FUNC_ROT: begin
        // The intermediate is rounded and clamped; conj(q) stays at full width.
        t      = ham_product(qw, widen(p), sat);
        cq     = '{qw.w, -qw.x, -qw.y, -qw.z};
        pred.r = ham_product(widen(t), cq, sat);
      end
      default: pred.r = '0;
    endcase
    pred.sat = sat;
    return pred;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [QW-1:0] pick_comp(input int unsigned style);
    int unsigned s;
    s = (style == STYLE_MIXED) ? $urandom_range(STYLE_FULL, STYLE_EDGE) : style;
    case (s)
      STYLE_FULL: return QW'($urandom);
      // Unit scale: -1.0 .. +1.0 inclusive.
      STYLE_UNIT: return QW'($urandom_range(0, 32768)) - ONE;
      default: begin
        case ($urandom_range(0, 6))
          0:       return Q_MIN;
          1:       return Q_MAX;
          2:       return 16'sd0;
          3:       return 16'sd1;
          4:       return -16'sd1;
          5:       return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic quat_t pick_quat(input int unsigned style);
    quat_t v;
    v.w = pick_comp(style);
    v.x = pick_comp(style);
    v.y = pick_comp(style);
    v.z = pick_comp(style);
    return v;
  endfunction

  // Offer one item, optionally after an idle burst, and hold it until taken.
  // Record its expected result at the accepting edge.
  task automatic drive_item(input logic [1:0] func, input quat_t q, input quat_t p,
                            input logic typed, input quat_result_t known);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cmd_ch.func  <= func;
    cmd_ch.q_w   <= q.w;
    cmd_ch.q_x   <= q.x;
    cmd_ch.q_y   <= q.y;
    cmd_ch.q_z   <= q.z;
    cmd_ch.p_w   <= p.w;
    cmd_ch.p_x   <= p.x;
    cmd_ch.p_y   <= p.y;
    cmd_ch.p_z   <= p.z;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    pending_quats.push_back(typed ? known : predict_quat(func, q, p));
  endtask

  // ---------------------------------------------------------------------------
  // Command side: reset, directed table, random items, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    quat_t       q;
    quat_t       p;
    logic [1:0]  func;
    int unsigned pick;
    int unsigned style;

    // Drive every input to a known value before the first edge.
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.func  = FUNC_NONE;
    cmd_ch.q_w   = '0;
    cmd_ch.q_x   = '0;
    cmd_ch.q_y   = '0;
    cmd_ch.q_z   = '0;
    cmd_ch.p_w   = '0;
    cmd_ch.p_x   = '0;
    cmd_ch.p_y   = '0;
    cmd_ch.p_z   = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].func, dir_rows[i].q, dir_rows[i].p, dir_rows[i].typed,
                 dir_rows[i].known);
    end

    // Random items. Change the gap density every hundred items so that some
    // stretches stream back to back; stop idling entirely near the end.
    for (int i = 0; i < RAND_N; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          2:       gap_pct = 35;
          default: gap_pct = 60;
        endcase
      end
      calm = (i >= RAND_N - CALM_N);

      // Weight the operations toward the two product paths.
      pick = $urandom_range(0, 15);
      if (pick < 6) begin
        func = FUNC_MUL;
      end else if (pick < 10) begin
        func = FUNC_CONJ;
      end else if (pick < 15) begin
        func = FUNC_ROT;
      end else begin
        func = FUNC_NONE;
      end

      // Mostly unit-scale values so rotations stay meaningful; the rest go
      // full range or mix full, unit and edge values per component.
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        style = STYLE_UNIT;
      end else if (pick < 8) begin
        style = STYLE_FULL;
      end else begin
        style = STYLE_MIXED;
      end
      q = pick_quat(style);
      p = pick_quat(style);
      drive_item(func, q, p, 1'b0, '0);
    end

    // Drop valid, let every expected result arrive, then run on for DRAIN_CYCLES
    // so a stray extra result would still be caught.
    cmd_ch.valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall in random bursts and check each accepted item.
  // ---------------------------------------------------------------------------
  initial begin
    quat_result_t want;
    int unsigned  stall_left;
    int unsigned  stall_pct;
    int unsigned  window;

    res_ch.ready = 1'b0;
    stall_left   = 0;
    stall_pct    = 20;
    window       = 0;

    forever begin
      @(posedge clk);

      if (res_ch.valid && res_ch.ready) begin
        if (pending_quats.size() == 0) begin
          $error("result with nothing expected: r = %0d %0d %0d %0d, saturated = %0b",
                 res_ch.r_w, res_ch.r_x, res_ch.r_y, res_ch.r_z, res_ch.saturated);
          mismatches++;
        end else begin
          want = pending_quats.pop_front();
          if (res_ch.r_w !== want.r.w) begin
            $error("r_w: expected %0d, got %0d", want.r.w, res_ch.r_w);
            mismatches++;
          end
          if (res_ch.r_x !== want.r.x) begin
            $error("r_x: expected %0d, got %0d", want.r.x, res_ch.r_x);
            mismatches++;
          end
          if (res_ch.r_y !== want.r.y) begin
            $error("r_y: expected %0d, got %0d", want.r.y, res_ch.r_y);
            mismatches++;
          end
          if (res_ch.r_z !== want.r.z) begin
            $error("r_z: expected %0d, got %0d", want.r.z, res_ch.r_z);
            mismatches++;
          end
          if (res_ch.saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, res_ch.saturated);
            mismatches++;
          end
        end
      end

      // Reselect the stall density whenever the window count runs out.
      if (window == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          2:       stall_pct = 30;
          default: stall_pct = 60;
        endcase
        window = 150;
      end else begin
        window--;
      end

      // A stall covers this edge plus stall_left more.
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 16);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hdl/qmr_pkg.sv
hdl/qmr_if.sv
hdl/qmr_hamilton.sv
hdl/quaternion_multiply_rotate.sv
test/quaternion_multiply_rotate_test.sv
